[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising edge of aclk; it is off while reset is held.
`define KAB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check that a condition seen at one edge is followed by another in the next cycle.
`define KAB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/kab_pkg.sv]
`default_nettype none

package kab_pkg;

    // Field and word widths.
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 24;
    localparam int MEAS_W    = 25;
    localparam int GYRO_W    = 28;
    localparam int DT_W      = 17;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 64;
    localparam int CFG_IDX_W = 2;
    localparam int ACC_W     = 35;
    localparam int PC_W      = 6;

    // Configuration register indexes and their reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_Q_ANGLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_BIAS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_R_MEAS  = 2'd2;

    localparam logic [CFG_W-1:0] Q_ANGLE_RESET = 24'd66;
    localparam logic [CFG_W-1:0] Q_BIAS_RESET  = 24'd197;
    localparam logic [CFG_W-1:0] R_MEAS_RESET  = 24'd1966;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    // Micro-operations.
    typedef enum logic [3:0] {
        OP_LD,      // acc = A
        OP_ADD,     // acc = acc + A
        OP_SUB,     // acc = acc - A
        OP_RSB,     // acc = A - acc
        OP_MUL,     // product register = |A| * |B|
        OP_MULW,    // acc = rounded, saturated product
        OP_DIV,     // acc = rounded, saturated A / B (waits for the divider)
        OP_JZ,      // jump when A is zero
        OP_JMP,     // unconditional jump
        OP_OUT      // hand the estimates to the output register and stop
    } op_t;

    // Operand and destination selects. R_ZERO as a destination means no write.
    typedef enum logic [4:0] {
        R_ZERO,
        R_ANG,
        R_BIAS,
        R_P00,
        R_P01,
        R_P10,
        R_P11,
        R_T0,
        R_T1,
        R_S,
        R_K0,
        R_K1,
        R_Y,
        R_MEAS,
        R_GYRO,
        R_DT,
        R_QA,
        R_QB,
        R_RNOISE
    } sel_t;

    typedef struct packed {
        op_t              op;
        sel_t             a;
        sel_t             b;
        sel_t             dst;
        logic [PC_W-1:0]  target;
    } uop_t;

    // Control from the sequencer to the datapath; en marks the cycle a step commits.
    typedef struct packed {
        logic  en;
        op_t   op;
        sel_t  a;
        sel_t  b;
        sel_t  dst;
    } ctl_t;

    localparam logic [PC_W-1:0] L_ZERO_GAIN = 6'd26;
    localparam logic [PC_W-1:0] L_CORRECT   = 6'd28;

    function automatic logic signed [DATA_W-1:0] sat64(input logic signed [63:0] v);
        if (v > SAT_MAX) begin
            return SAT_MAX[DATA_W-1:0];
        end else if (v < SAT_MIN) begin
            return SAT_MIN[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    endfunction

    function automatic uop_t mk(input op_t op, input sel_t a, input sel_t b,
                                input sel_t dst, input logic [PC_W-1:0] target);
        uop_t u;
        u.op     = op;
        u.a      = a;
        u.b      = b;
        u.dst    = dst;
        u.target = target;
        return u;
    endfunction

    // Filter program. P is updated in the order P10, P11, P00, P01 so that
    // the gain products always see the values from before the update.
    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            // Predict: rate, angle, covariance.
            6'd0:  u = mk(OP_LD,   R_GYRO,  R_ZERO, R_ZERO, '0);
            6'd1:  u = mk(OP_SUB,  R_BIAS,  R_ZERO, R_T1,   '0);
            6'd2:  u = mk(OP_MUL,  R_DT,    R_T1,   R_ZERO, '0);
            6'd3:  u = mk(OP_MULW, R_ZERO,  R_ZERO, R_ZERO, '0);
            6'd4:  u = mk(OP_ADD,  R_ANG,   R_ZERO, R_ANG,  '0);
            6'd5:  u = mk(OP_MUL,  R_DT,    R_P11,  R_ZERO, '0);
            6'd6:  u = mk(OP_MULW, R_ZERO,  R_ZERO, R_T0,   '0);
            6'd7:  u = mk(OP_SUB,  R_P01,   R_ZERO, R_ZERO, '0);
            6'd8:  u = mk(OP_SUB,  R_P10,   R_ZERO, R_ZERO, '0);
            6'd9:  u = mk(OP_ADD,  R_QA,    R_ZERO, R_T1,   '0);
            6'd10: u = mk(OP_MUL,  R_DT,    R_T1,   R_ZERO, '0);
            6'd11: u = mk(OP_MULW, R_ZERO,  R_ZERO, R_ZERO, '0);
            6'd12: u = mk(OP_ADD,  R_P00,   R_ZERO, R_P00,  '0);
            6'd13: u = mk(OP_LD,   R_P01,   R_ZERO, R_ZERO, '0);
            6'd14: u = mk(OP_SUB,  R_T0,    R_ZERO, R_P01,  '0);
            6'd15: u = mk(OP_LD,   R_P10,   R_ZERO, R_ZERO, '0);
            6'd16: u = mk(OP_SUB,  R_T0,    R_ZERO, R_P10,  '0);
            6'd17: u = mk(OP_MUL,  R_QB,    R_DT,   R_ZERO, '0);
            6'd18: u = mk(OP_MULW, R_ZERO,  R_ZERO, R_ZERO, '0);
            6'd19: u = mk(OP_ADD,  R_P11,   R_ZERO, R_P11,  '0);
            // Gain.
            6'd20: u = mk(OP_LD,   R_P00,   R_ZERO, R_ZERO, '0);
            6'd21: u = mk(OP_ADD,  R_RNOISE, R_ZERO, R_S,   '0);
            6'd22: u = mk(OP_JZ,   R_S,     R_ZERO, R_ZERO, L_ZERO_GAIN);
            6'd23: u = mk(OP_DIV,  R_P00,   R_S,    R_K0,   '0);
            6'd24: u = mk(OP_DIV,  R_P10,   R_S,    R_K1,   '0);
            6'd25: u = mk(OP_JMP,  R_ZERO,  R_ZERO, R_ZERO, L_CORRECT);
            6'd26: u = mk(OP_LD,   R_ZERO,  R_ZERO, R_K0,   '0);
            6'd27: u = mk(OP_LD,   R_ZERO,  R_ZERO, R_K1,   '0);
            // Correct: innovation, angle, bias.
            6'd28: u = mk(OP_LD,   R_MEAS,  R_ZERO, R_ZERO, '0);
            6'd29: u = mk(OP_SUB,  R_ANG,   R_ZERO, R_Y,    '0);
            6'd30: u = mk(OP_MUL,  R_K0,    R_Y,    R_ZERO, '0);
            6'd31: u = mk(OP_MULW, R_ZERO,  R_ZERO, R_ZERO, '0);
            6'd32: u = mk(OP_ADD,  R_ANG,   R_ZERO, R_ANG,  '0);
            6'd33: u = mk(OP_MUL,  R_K1,    R_Y,    R_ZERO, '0);
            6'd34: u = mk(OP_MULW, R_ZERO,  R_ZERO, R_ZERO, '0);
            6'd35: u = mk(OP_ADD,  R_BIAS,  R_ZERO, R_BIAS, '0);
            // Covariance update.
            6'd36: u = mk(OP_MUL,  R_K1,    R_P00,  R_ZERO, '0);
            6'd37: u = mk(OP_MULW, R_ZERO,  R_ZERO, R_ZERO, '0);
            6'd38: u = mk(OP_RSB,  R_P10,   R_ZERO, R_P10,  '0);
            6'd39: u = mk(OP_MUL,  R_K1,    R_P01,  R_ZERO, '0);
            6'd40: u = mk(OP_MULW, R_ZERO,  R_ZERO, R_ZERO, '0);
            6'd41: u = mk(OP_RSB,  R_P11,   R_ZERO, R_P11,  '0);
            6'd42: u = mk(OP_MUL,  R_K0,    R_P00,  R_ZERO, '0);
            6'd43: u = mk(OP_MULW, R_ZERO,  R_ZERO, R_ZERO, '0);
            6'd44: u = mk(OP_RSB,  R_P00,   R_ZERO, R_P00,  '0);
            6'd45: u = mk(OP_MUL,  R_K0,    R_P01,  R_ZERO, '0);
            6'd46: u = mk(OP_MULW, R_ZERO,  R_ZERO, R_ZERO, '0);
            6'd47: u = mk(OP_RSB,  R_P01,   R_ZERO, R_P01,  '0);
            6'd48: u = mk(OP_OUT,  R_ZERO,  R_ZERO, R_ZERO, '0);
            default: u = mk(OP_OUT, R_ZERO, R_ZERO, R_ZERO, '0);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

[rtl/kab_div.sv]
`default_nettype none

module kab_div (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic signed [kab_pkg::DATA_W-1:0]   num,
    input  wire logic signed [kab_pkg::DATA_W-1:0]   den,
    output logic                                     busy,
    output logic                                     done,
    output logic signed [kab_pkg::DATA_W-1:0]        quot
);

    // Restoring division of |num| * 2^16 + |den| / 2 by |den|, two bits a cycle.
    localparam int DW     = kab_pkg::DATA_W;
    localparam int NUM_W  = DW + 16;
    localparam int STEPS  = 2;
    localparam int ITERS  = NUM_W / STEPS;
    localparam int CNT_W  = $clog2(ITERS + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0] dq_reg, dq_next;
    logic [DW-1:0]    den_reg, den_next;
    logic             neg_reg, neg_next;

    logic [DW-1:0]    num_mag;
    logic [DW-1:0]    den_mag;
    logic [DW:0]      trial;
    logic [63:0]      q_wide;

    assign num_mag = kab_pkg::mag32(num);
    assign den_mag = kab_pkg::mag32(den);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        trial     = '0;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ITERS);
            rem_next  = '0;
            dq_next   = {num_mag, 16'b0} + NUM_W'(den_mag >> 1);
            den_next  = den_mag;
            neg_next  = num[DW-1] ^ den[DW-1];
        end else if (busy_reg) begin
            for (int i = 0; i < STEPS; i++) begin
                trial   = {rem_next, dq_next[NUM_W-1]};
                dq_next = {dq_next[NUM_W-2:0], 1'b0};
                if (trial >= {1'b0, den_reg}) begin
                    rem_next   = DW'(trial - {1'b0, den_reg});
                    dq_next[0] = 1'b1;
                end else begin
                    rem_next = trial[DW-1:0];
                end
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign q_wide = 64'(dq_reg);
    assign quot   = kab_pkg::sat64(neg_reg ? -$signed(q_wide) : $signed(q_wide));
    assign busy   = busy_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

[rtl/kab_seq.sv]
`default_nettype none

module kab_seq (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic          a_zero,
    input  wire logic          div_done,
    input  wire logic          out_free,
    output kab_pkg::ctl_t      ctl,
    output logic               div_start,
    output logic               busy
);

    localparam int PW = kab_pkg::PC_W;

    logic            run_reg, run_next;
    logic            div_run_reg, div_run_next;
    logic [PW-1:0]   pc_reg, pc_next;
    logic [PW-1:0]   pc_inc;
    kab_pkg::uop_t   uop;

    assign uop    = kab_pkg::ucode(pc_reg);
    assign pc_inc = pc_reg + PW'(1);

    always_comb begin
        run_next     = run_reg;
        div_run_next = div_run_reg;
        pc_next      = pc_reg;
        div_start    = 1'b0;
        ctl.en       = 1'b0;
        ctl.op       = uop.op;
        ctl.a        = uop.a;
        ctl.b        = uop.b;
        ctl.dst      = uop.dst;
        if (!run_reg) begin
            if (start) begin
                run_next = 1'b1;
                pc_next  = '0;
            end
        end else begin
            case (uop.op)
                kab_pkg::OP_DIV: begin
                    if (!div_run_reg) begin
                        div_start    = 1'b1;
                        div_run_next = 1'b1;
                    end else if (div_done) begin
                        ctl.en       = 1'b1;
                        div_run_next = 1'b0;
                        pc_next      = pc_inc;
                    end
                end
                kab_pkg::OP_JZ: begin
                    pc_next = a_zero ? uop.target : pc_inc;
                end
                kab_pkg::OP_JMP: begin
                    pc_next = uop.target;
                end
                kab_pkg::OP_OUT: begin
                    if (out_free) begin
                        ctl.en   = 1'b1;
                        run_next = 1'b0;
                    end
                end
                default: begin
                    ctl.en  = 1'b1;
                    pc_next = pc_inc;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= 1'b0;
            div_run_reg <= 1'b0;
            pc_reg      <= '0;
        end else begin
            run_reg     <= run_next;
            div_run_reg <= div_run_next;
            pc_reg      <= pc_next;
        end
    end

    assign busy = run_reg;

endmodule

`default_nettype wire

[rtl/kab_dp.sv]
`default_nettype none

module kab_dp (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  load,
    input  wire logic signed [kab_pkg::MEAS_W-1:0]     meas_in,
    input  wire logic signed [kab_pkg::GYRO_W-1:0]     gyro_in,
    input  wire logic        [kab_pkg::DT_W-1:0]       dt_in,
    input  wire logic        [kab_pkg::CFG_W-1:0]      q_angle,
    input  wire logic        [kab_pkg::CFG_W-1:0]      q_bias,
    input  wire logic        [kab_pkg::CFG_W-1:0]      r_meas,
    input  kab_pkg::ctl_t                              ctl,
    input  wire logic signed [kab_pkg::DATA_W-1:0]     div_quot,
    output logic signed [kab_pkg::DATA_W-1:0]          a_val,
    output logic signed [kab_pkg::DATA_W-1:0]          b_val,
    output logic                                       a_zero,
    output logic signed [kab_pkg::DATA_W-1:0]          angle,
    output logic signed [kab_pkg::DATA_W-1:0]          bias
);

    localparam int DW = kab_pkg::DATA_W;
    localparam int AW = kab_pkg::ACC_W;

    // Filter state.
    logic signed [DW-1:0] ang_reg, bias_reg;
    logic signed [DW-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    // Scratch registers of the program.
    logic signed [DW-1:0] t0_reg, t1_reg, s_reg, k0_reg, k1_reg, y_reg;
    // Item fields held for the run.
    logic signed [kab_pkg::MEAS_W-1:0] meas_reg;
    logic signed [kab_pkg::GYRO_W-1:0] gyro_reg;
    logic        [kab_pkg::DT_W-1:0]   dt_reg;

    logic signed [AW-1:0] acc_reg, acc_next;
    logic [63:0]          prod_reg, prod_next;
    logic                 neg_reg, neg_next;

    logic [63:0]          rnd;
    logic signed [DW-1:0] mul_res;
    logic signed [DW-1:0] res;
    logic                 wr;

    always_comb begin
        case (ctl.a)
            kab_pkg::R_ANG:    a_val = ang_reg;
            kab_pkg::R_BIAS:   a_val = bias_reg;
            kab_pkg::R_P00:    a_val = p00_reg;
            kab_pkg::R_P01:    a_val = p01_reg;
            kab_pkg::R_P10:    a_val = p10_reg;
            kab_pkg::R_P11:    a_val = p11_reg;
            kab_pkg::R_T0:     a_val = t0_reg;
            kab_pkg::R_T1:     a_val = t1_reg;
            kab_pkg::R_S:      a_val = s_reg;
            kab_pkg::R_K0:     a_val = k0_reg;
            kab_pkg::R_K1:     a_val = k1_reg;
            kab_pkg::R_Y:      a_val = y_reg;
            kab_pkg::R_MEAS:   a_val = DW'(meas_reg);
            kab_pkg::R_GYRO:   a_val = DW'(gyro_reg);
            kab_pkg::R_DT:     a_val = {{(DW - kab_pkg::DT_W){1'b0}}, dt_reg};
            kab_pkg::R_QA:     a_val = {{(DW - kab_pkg::CFG_W){1'b0}}, q_angle};
            kab_pkg::R_QB:     a_val = {{(DW - kab_pkg::CFG_W){1'b0}}, q_bias};
            kab_pkg::R_RNOISE: a_val = {{(DW - kab_pkg::CFG_W){1'b0}}, r_meas};
            default:           a_val = '0;
        endcase
    end

    always_comb begin
        case (ctl.b)
            kab_pkg::R_ANG:    b_val = ang_reg;
            kab_pkg::R_BIAS:   b_val = bias_reg;
            kab_pkg::R_P00:    b_val = p00_reg;
            kab_pkg::R_P01:    b_val = p01_reg;
            kab_pkg::R_P10:    b_val = p10_reg;
            kab_pkg::R_P11:    b_val = p11_reg;
            kab_pkg::R_T0:     b_val = t0_reg;
            kab_pkg::R_T1:     b_val = t1_reg;
            kab_pkg::R_S:      b_val = s_reg;
            kab_pkg::R_K0:     b_val = k0_reg;
            kab_pkg::R_K1:     b_val = k1_reg;
            kab_pkg::R_Y:      b_val = y_reg;
            kab_pkg::R_MEAS:   b_val = DW'(meas_reg);
            kab_pkg::R_GYRO:   b_val = DW'(gyro_reg);
            kab_pkg::R_DT:     b_val = {{(DW - kab_pkg::DT_W){1'b0}}, dt_reg};
            kab_pkg::R_QA:     b_val = {{(DW - kab_pkg::CFG_W){1'b0}}, q_angle};
            kab_pkg::R_QB:     b_val = {{(DW - kab_pkg::CFG_W){1'b0}}, q_bias};
            kab_pkg::R_RNOISE: b_val = {{(DW - kab_pkg::CFG_W){1'b0}}, r_meas};
            default:           b_val = '0;
        endcase
    end

    assign a_zero = (a_val == '0);

    // Magnitude product registered at the multiply step; rounding to nearest, ties away from zero,
    // and saturation in the step after.
    assign prod_next = 64'(kab_pkg::mag32(a_val)) * 64'(kab_pkg::mag32(b_val));
    assign neg_next  = a_val[DW-1] ^ b_val[DW-1];
    assign rnd       = (prod_reg + 64'd32768) >> 16;
    assign mul_res   = kab_pkg::sat64(neg_reg ? -$signed(rnd) : $signed(rnd));

    always_comb begin
        case (ctl.op)
            kab_pkg::OP_LD:   acc_next = AW'(a_val);
            kab_pkg::OP_ADD:  acc_next = acc_reg + AW'(a_val);
            kab_pkg::OP_SUB:  acc_next = acc_reg - AW'(a_val);
            kab_pkg::OP_RSB:  acc_next = AW'(a_val) - acc_reg;
            kab_pkg::OP_MULW: acc_next = AW'(mul_res);
            kab_pkg::OP_DIV:  acc_next = AW'(div_quot);
            default:          acc_next = acc_reg;
        endcase
        res = kab_pkg::sat64(64'(acc_next));
        wr  = ctl.en && (ctl.op inside {kab_pkg::OP_LD, kab_pkg::OP_ADD, kab_pkg::OP_SUB,
                                        kab_pkg::OP_RSB, kab_pkg::OP_MULW, kab_pkg::OP_DIV});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ang_reg  <= '0;
            bias_reg <= '0;
            p00_reg  <= '0;
            p01_reg  <= '0;
            p10_reg  <= '0;
            p11_reg  <= '0;
        end else if (wr) begin
            case (ctl.dst)
                kab_pkg::R_ANG:  ang_reg  <= res;
                kab_pkg::R_BIAS: bias_reg <= res;
                kab_pkg::R_P00:  p00_reg  <= res;
                kab_pkg::R_P01:  p01_reg  <= res;
                kab_pkg::R_P10:  p10_reg  <= res;
                kab_pkg::R_P11:  p11_reg  <= res;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            case (ctl.dst)
                kab_pkg::R_T0: t0_reg <= res;
                kab_pkg::R_T1: t1_reg <= res;
                kab_pkg::R_S:  s_reg  <= res;
                kab_pkg::R_K0: k0_reg <= res;
                kab_pkg::R_K1: k1_reg <= res;
                kab_pkg::R_Y:  y_reg  <= res;
                default: ;
            endcase
        end
        if (ctl.en) begin
            acc_reg <= acc_next;
        end
        if (ctl.en && ctl.op == kab_pkg::OP_MUL) begin
            prod_reg <= prod_next;
            neg_reg  <= neg_next;
        end
        if (load) begin
            meas_reg <= meas_in;
            gyro_reg <= gyro_in;
            dt_reg   <= dt_in;
        end
    end

    assign angle = ang_reg;
    assign bias  = bias_reg;

endmodule

`default_nettype wire

[rtl/kalman_angle_bias_filter.sv]
// A new item is accepted only once the program has finished with the previous one.
// The two gain divisions run in the shared two-bit-per-cycle divider; both are
// skipped when P00 + R is zero.
// A result waiting on m_tready holds the program only at its final step.
// Reset (aresetn, synchronous, active low) clears the angle, bias and covariance,
// loads the noise registers with their defaults and empties the output register.
`default_nettype none
`include "assert_macros.svh"

module kalman_angle_bias_filter (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    // Input items.
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // [24:0] measured_angle, [52:25] gyro_rate, [69:53] time_step, [71:70] zero
    input  wire logic [kab_pkg::S_TDATA_W-1:0]        s_tdata,

    // Result items.
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [31:0] filtered_angle, [63:32] bias_estimate
    output logic [kab_pkg::M_TDATA_W-1:0]             m_tdata,

    // Configuration writes.
    input  wire logic                                 cfg_wr_en,
    input  wire logic [kab_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [kab_pkg::CFG_W-1:0]            cfg_wdata
);

    localparam int DW = kab_pkg::DATA_W;

    // Noise registers: angle process noise, bias process noise, measurement noise.
    logic [kab_pkg::CFG_W-1:0] q_angle_reg;
    logic [kab_pkg::CFG_W-1:0] q_bias_reg;
    logic [kab_pkg::CFG_W-1:0] r_meas_reg;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [kab_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic                 accept;
    logic                 seq_busy;
    logic                 out_free;
    logic                 out_load;
    kab_pkg::ctl_t        seq_ctl;

    logic                 div_start;
    logic                 div_busy;
    logic                 div_done;
    logic signed [DW-1:0] div_quot;

    logic signed [DW-1:0] a_val;
    logic signed [DW-1:0] b_val;
    logic                 a_zero;
    logic signed [DW-1:0] angle;
    logic signed [DW-1:0] bias;

    // An item is taken only while the program is stopped. The output register
    // decouples the two sides: the next item may enter while the previous
    // result is still waiting to be taken.
    assign s_tready = !seq_busy;
    assign accept   = s_tvalid && s_tready;

    // The final step of the program moves the estimates into the output
    // register, and waits there if that register is still full.
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = seq_ctl.en && (seq_ctl.op == kab_pkg::OP_OUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_angle_reg <= kab_pkg::Q_ANGLE_RESET;
            q_bias_reg  <= kab_pkg::Q_BIAS_RESET;
            r_meas_reg  <= kab_pkg::R_MEAS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                kab_pkg::CFG_Q_ANGLE: q_angle_reg <= cfg_wdata;
                kab_pkg::CFG_Q_BIAS:  q_bias_reg  <= cfg_wdata;
                kab_pkg::CFG_R_MEAS:  r_meas_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer: program counter, step decode, jumps and the divider handshake.
    kab_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .a_zero    (a_zero),
        .div_done  (div_done),
        .out_free  (out_free),
        .ctl       (seq_ctl),
        .div_start (div_start),
        .busy      (seq_busy)
    );

    // Datapath: filter state, scratch registers, accumulator and multiplier.
    kab_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .meas_in  (s_tdata[24:0]),
        .gyro_in  (s_tdata[52:25]),
        .dt_in    (s_tdata[69:53]),
        .q_angle  (q_angle_reg),
        .q_bias   (q_bias_reg),
        .r_meas   (r_meas_reg),
        .ctl      (seq_ctl),
        .div_quot (div_quot),
        .a_val    (a_val),
        .b_val    (b_val),
        .a_zero   (a_zero),
        .angle    (angle),
        .bias     (bias)
    );

    // Divider shared by both gains; the program skips it when P00 + R is zero.
    kab_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (a_val),
        .den     (b_val),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {bias, angle};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks that s_tready falls after an item is taken; it stays low until the program ends.
    `KAB_ASSERT_NEXT(a_accept_closes, accept, !s_tready, "item accepted while running")
    // The result must never overwrite one that has not been taken.
    `KAB_ASSERT(a_out_no_overwrite, out_load |-> (!m_tvalid_reg || m_tready), "result lost")
    // A division is only started while the divider is free.
    `KAB_ASSERT(a_div_start_free, div_start |-> !div_busy, "divider restarted while busy")
    // A quotient only arrives while the program waits on a division step.
    `KAB_ASSERT(a_div_done_step, div_done |-> (seq_ctl.op == kab_pkg::OP_DIV), "stray quotient")

endmodule

`default_nettype wire
